### rtl/mndr_pkg.sv
// Shared types and constants for the neighbor table / DR election block.
// No dependencies; imported by mndr_table and the top level.
`default_nettype none
package mndr_pkg;

	localparam int unsigned MaxNeighbors = 32;

	localparam logic [31:0] OwnAddrRst   = 32'd0;
	localparam logic [31:0] OwnPriRst    = 32'd1;
	localparam logic [15:0] OwnDelayRst  = 16'd500;
	localparam logic [15:0] OwnOvrRst    = 16'd2500;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_UPD = 2'd1;
	localparam logic [1:0] REQ_DEL = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_DUP      = 2'd3;

	localparam logic [1:0] REG_OWN_ADDR  = 2'd0;
	localparam logic [1:0] REG_OWN_PRI   = 2'd1;
	localparam logic [1:0] REG_OWN_DELAY = 2'd2;
	localparam logic [1:0] REG_OWN_OVR   = 2'd3;

	typedef struct packed {
		logic [15:0] interval;
		logic [15:0] delay;
		logic        has_lan;
		logic        has_pri;
		logic [31:0] priority_v;
		logic [31:0] addr;
	} entry_t;

endpackage
`default_nettype wire

### rtl/mndr_table.sv
// Neighbor table: one-write one-read memory of entries plus valid flags.
// Depends on mndr_pkg for entry_t.
`default_nettype none
module mndr_table #(
	parameter int unsigned MAX_NEIGHBORS = mndr_pkg::MaxNeighbors,
	parameter int unsigned IW = 5
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   we,
	input  wire  [IW-1:0]         waddr,
	input  mndr_pkg::entry_t      wentry,
	input  wire                   set_valid,
	input  wire                   clr_valid,
	input  wire  [IW-1:0]         raddr,
	output mndr_pkg::entry_t      rentry,
	output logic                  rvalid
);
	import mndr_pkg::*;

	entry_t mem [MAX_NEIGHBORS];
	logic [MAX_NEIGHBORS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wentry;
		end
		rentry <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid  <= 1'b0;
		end else begin
			if (set_valid) begin
				valid_q[waddr] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[waddr] <= 1'b0;
			end
			rvalid <= valid_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/multicast_neighbor_dr_election_core.sv
// Top level: request sequencer, shared compare datapath, APB registers, output word.
// Depends on mndr_pkg and mndr_table.
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  request word (tdata, tuser)
// m_*       out        m_tvalid/m_tready  result word (tdata, tuser)
// apb       in/out     psel/penable       own address, priority, delay, override
//
// Lookup, optional rescan and election scans each step through the table, one table read per cycle;
// a result is loaded after the lookup scan, the action state S_ACT, the rescan and election scans
// where needed and the load state S_FIN; s_tready returns the cycle after the load.
// Reset clears valid flags, counts, maxima and the current DR; no clearing pass is needed.
// A result waits in its output register while the next word may be taken; a new result
// stalls in its last step until the previous one is taken.
`default_nettype none
module multicast_neighbor_dr_election_core #(
	parameter int unsigned MAX_NEIGHBORS = mndr_pkg::MaxNeighbors
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// [31:0] neighbor_addr, [63:32] neighbor_priority, [64] has_dr_priority,
	// [65] has_lan_delay, [81:66] prop_delay_ms, [97:82] override_ms, rest zero
	input  wire  [103:0] s_tdata,
	// [1:0] req_type
	input  wire  [1:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// [31:0] dr_address, [32] dr_changed, [33] i_am_dr, [49:34] highest_delay,
	// [65:50] highest_interval, [71:66] no_priority_count, [77:72] no_landelay_count
	output logic [79:0]  m_tdata,
	// [1:0] status
	output logic [1:0]   m_tuser,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [3:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import mndr_pkg::*;

	localparam int unsigned IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOOK   = 6'b000010,
		S_ACT    = 6'b000100,
		S_RESCAN = 6'b001000,
		S_ELECT  = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t state_q;

	logic [31:0] own_addr_q, own_pri_q;
	logic [15:0] own_delay_q, own_ovr_q;

	logic [1:0]  req_q;
	logic [31:0] addr_q, pri_q;
	logic        hpri_q, hlan_q;
	logic [15:0] dly_q, ovr_q;

	logic [IW:0]   cnt_q;
	logic          pend_s1;
	logic [IW-1:0] tag_s1;

	logic          found_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	entry_t        hit_q;

	logic [31:0] dr_q, bp_q, cur_dr_q;
	logic [15:0] md_q, mi_q, max_d_q, max_i_q;
	logic        do_d_q, do_i_q, changed_q;
	logic [1:0]  status_q;
	logic [CW-1:0] nopri_q, nolan_q;

	logic        we, set_v, clr_v;
	logic [IW-1:0] waddr;
	entry_t      wentry, rentry;
	logic        rvalid;

	logic scan_done, flip, prio_moved, take;
	logic [CW-1:0] nopri_upd, nolan_upd, nopri_del, nolan_del;
	logic [15:0] nopri_w, nolan_w;
	logic cfg_wr;

	mndr_table #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .IW(IW)) u_table (
		.clk(clk), .arst_n(arst_n), .we(we), .waddr(waddr), .wentry(wentry),
		.set_valid(set_v), .clr_valid(clr_v), .raddr(cnt_q[IW-1:0]),
		.rentry(rentry), .rvalid(rvalid)
	);

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		unique case (paddr[3:2])
			REG_OWN_ADDR:  prdata = own_addr_q;
			REG_OWN_PRI:   prdata = own_pri_q;
			REG_OWN_DELAY: prdata = {16'd0, own_delay_q};
			REG_OWN_OVR:   prdata = {16'd0, own_ovr_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign scan_done = (cnt_q == (IW+1)'(MAX_NEIGHBORS)) && !pend_s1;

	assign flip       = (hit_q.has_pri != hpri_q);
	assign prio_moved = flip || (hit_q.priority_v != pri_q);

	always_comb begin
		nopri_upd = nopri_q;
		if (flip) begin
			if (hpri_q) begin
				nopri_upd = (nopri_q != '0) ? nopri_q - 1'b1 : nopri_q;
			end else begin
				nopri_upd = nopri_q + 1'b1;
			end
		end
		nolan_upd = nolan_q;
		if (hit_q.has_lan != hlan_q) begin
			if (hit_q.has_lan) begin
				nolan_upd = nolan_q + 1'b1;
			end else begin
				nolan_upd = (nolan_q != '0) ? nolan_q - 1'b1 : nolan_q;
			end
		end
		nopri_del = (!hit_q.has_pri && nopri_q != '0) ? nopri_q - 1'b1 : nopri_q;
		nolan_del = (!hit_q.has_lan && nolan_q != '0) ? nolan_q - 1'b1 : nolan_q;
	end

	always_comb begin
		if (nopri_q != '0) begin
			take = rentry.addr > dr_q;
		end else begin
			take = (rentry.priority_v > bp_q) ||
			       ((rentry.priority_v == bp_q) && (rentry.addr > dr_q));
		end
	end

	always_comb begin
		we     = 1'b0;
		set_v  = 1'b0;
		clr_v  = 1'b0;
		waddr  = hit_idx_q;
		wentry = hit_q;
		if (state_q == S_ACT) begin
			unique case (req_q)
				REQ_ADD: begin
					waddr  = free_idx_q;
					wentry = '{interval: ovr_q, delay: dly_q, has_lan: hlan_q,
					           has_pri: hpri_q, priority_v: pri_q, addr: addr_q};
					we     = !found_q && free_q;
					set_v  = !found_q && free_q;
				end
				REQ_UPD: begin
					wentry.priority_v = hpri_q ? pri_q : 32'd0;
					wentry.has_pri    = hpri_q;
					wentry.has_lan    = hlan_q;
					we = found_q;
				end
				REQ_DEL: clr_v = found_q;
				default: ;
			endcase
		end
	end

	assign nopri_w = 16'(nopri_q);
	assign nolan_w = 16'(nolan_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q  <= OwnAddrRst;
			own_pri_q   <= OwnPriRst;
			own_delay_q <= OwnDelayRst;
			own_ovr_q   <= OwnOvrRst;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_OWN_ADDR:  own_addr_q  <= pwdata;
				REG_OWN_PRI:   own_pri_q   <= pwdata;
				REG_OWN_DELAY: own_delay_q <= pwdata[15:0];
				REG_OWN_OVR:   own_ovr_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q  <= s_tuser;
			addr_q <= s_tdata[31:0];
			pri_q  <= s_tdata[63:32];
			hpri_q <= s_tdata[64];
			hlan_q <= s_tdata[65];
			dly_q  <= s_tdata[81:66];
			ovr_q  <= s_tdata[97:82];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			pend_s1    <= 1'b0;
			tag_s1     <= '0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			hit_q      <= '0;
			dr_q       <= '0;
			bp_q       <= '0;
			md_q       <= '0;
			mi_q       <= '0;
			do_d_q     <= 1'b0;
			do_i_q     <= 1'b0;
			changed_q  <= 1'b0;
			status_q   <= ST_OK;
			cur_dr_q   <= '0;
			max_d_q    <= '0;
			max_i_q    <= '0;
			nopri_q    <= '0;
			nolan_q    <= '0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != S_FIN) begin
				m_tvalid <= 1'b0;
			end
			if (state_q == S_LOOK || state_q == S_RESCAN || state_q == S_ELECT) begin
				if (cnt_q != (IW+1)'(MAX_NEIGHBORS)) begin
					cnt_q   <= cnt_q + 1'b1;
					pend_s1 <= 1'b1;
					tag_s1  <= cnt_q[IW-1:0];
				end else begin
					pend_s1 <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q   <= S_LOOK;
						cnt_q     <= '0;
						pend_s1   <= 1'b0;
						found_q   <= 1'b0;
						free_q    <= 1'b0;
						changed_q <= 1'b0;
						status_q  <= ST_OK;
					end
				end
				S_LOOK: begin
					if (pend_s1) begin
						if (rvalid && rentry.addr == addr_q && !found_q) begin
							found_q   <= 1'b1;
							hit_idx_q <= tag_s1;
							hit_q     <= rentry;
						end
						if (!rvalid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= tag_s1;
						end
					end
					if (scan_done) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					cnt_q   <= '0;
					pend_s1 <= 1'b0;
					dr_q    <= own_addr_q;
					bp_q    <= own_pri_q;
					md_q    <= own_delay_q;
					mi_q    <= own_ovr_q;
					state_q <= S_FIN;
					unique case (req_q)
						REQ_ADD: begin
							if (found_q) begin
								status_q <= ST_DUP;
							end else if (!free_q) begin
								status_q <= ST_FULL;
							end else begin
								if (dly_q > max_d_q) max_d_q <= dly_q;
								if (ovr_q > max_i_q) max_i_q <= ovr_q;
								if (!hlan_q) nolan_q <= nolan_q + 1'b1;
								if (!hpri_q) nopri_q <= nopri_q + 1'b1;
								state_q <= S_ELECT;
							end
						end
						REQ_UPD: begin
							if (!found_q) begin
								status_q <= ST_NOTFOUND;
							end else begin
								nopri_q <= nopri_upd;
								nolan_q <= nolan_upd;
								if (prio_moved) state_q <= S_ELECT;
							end
						end
						REQ_DEL: begin
							if (!found_q) begin
								status_q <= ST_NOTFOUND;
							end else begin
								nopri_q <= nopri_del;
								nolan_q <= nolan_del;
								do_d_q  <= (nolan_del == '0) && (hit_q.delay == max_d_q);
								do_i_q  <= (nolan_del == '0) && (hit_q.interval == max_i_q);
								if ((nolan_del == '0) && ((hit_q.delay == max_d_q) ||
								    (hit_q.interval == max_i_q))) begin
									state_q <= S_RESCAN;
								end else begin
									state_q <= S_ELECT;
								end
							end
						end
						default: ;
					endcase
				end
				S_RESCAN: begin
					if (pend_s1 && rvalid) begin
						if (rentry.delay > md_q)    md_q <= rentry.delay;
						if (rentry.interval > mi_q) mi_q <= rentry.interval;
					end
					if (scan_done) begin
						if (do_d_q) max_d_q <= md_q;
						if (do_i_q) max_i_q <= mi_q;
						cnt_q   <= '0;
						state_q <= S_ELECT;
					end
				end
				S_ELECT: begin
					if (pend_s1 && rvalid && take) begin
						dr_q <= rentry.addr;
						bp_q <= rentry.priority_v;
					end
					if (scan_done) begin
						changed_q <= (dr_q != cur_dr_q);
						cur_dr_q  <= dr_q;
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser  <= status_q;
						m_tdata  <= {2'b00,
						             (nolan_w > 16'd63) ? 6'd63 : nolan_w[5:0],
						             (nopri_w > 16'd63) ? 6'd63 : nopri_w[5:0],
						             max_i_q, max_d_q,
						             (cur_dr_q == own_addr_q), changed_q, cur_dr_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_LOOK))
		else $error("accepted word did not start the lookup scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		(nopri_q <= CW'(MAX_NEIGHBORS)) && (nolan_q <= CW'(MAX_NEIGHBORS)))
		else $error("option counts exceed table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && m_tvalid && !m_tready) |=> (state_q == S_FIN))
		else $error("result dropped while output stalled");

endmodule
`default_nettype wire

### verif/tb.sv
// Testbench for multicast_neighbor_dr_election_core: neighbor add/update/delete
// requests over the request stream, DR election results checked against a local predictor.
// Depends on mndr_pkg and the RTL top level.
`default_nettype none
module tb;
	import mndr_pkg::*;

	localparam int NB = 32;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]  req;
		logic [31:0] addr;
		logic [31:0] pri;
		logic        has_pri;
		logic        has_lan;
		logic [15:0] delay;
		logic [15:0] ovr;
	} hello_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] dr;
		logic        changed;
		logic        self_dr;
		logic [15:0] hi_delay;
		logic [15:0] hi_ivl;
		logic [5:0]  nopri;
		logic [5:0]  nolan;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [103:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [79:0] m_tdata;
	logic [1:0] m_tuser;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	multicast_neighbor_dr_election_core dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state
	logic [31:0] p_own_addr = OwnAddrRst, p_own_pri = OwnPriRst;
	logic [15:0] p_own_delay = OwnDelayRst, p_own_ovr = OwnOvrRst;
	logic        t_valid [NB];
	logic [31:0] t_addr [NB];
	logic [31:0] t_pri [NB];
	logic        t_fpri [NB];
	logic        t_flan [NB];
	logic [15:0] t_delay [NB];
	logic [15:0] t_ivl [NB];
	logic [31:0] cur_dr = 0;
	logic [15:0] max_delay = 0, max_ivl = 0;
	int          nopri = 0, nolan = 0;

	verdict_t pending_verdicts[$];
	int errors = 0, checked = 0, sent = 0, cycles = 0;
	bit hold_off = 0;
	logic [31:0] known_addrs[$];

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %0d: %s got %h want %h", checked, what, got, want);
	endtask

	function automatic int find_addr(logic [31:0] a);
		for (int i = 0; i < NB; i++)
			if (t_valid[i] && t_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic bit run_election();
		logic [31:0] old, dr, pr;
		old = cur_dr;
		dr = p_own_addr;
		pr = p_own_pri;
		for (int i = 0; i < NB; i++) begin
			if (!t_valid[i]) continue;
			if (nopri != 0) begin
				if (t_addr[i] > dr) dr = t_addr[i];
			end else if (t_pri[i] > pr || (t_pri[i] == pr && t_addr[i] > dr)) begin
				dr = t_addr[i];
				pr = t_pri[i];
			end
		end
		cur_dr = dr;
		return dr != old;
	endfunction

	function automatic verdict_t predict_verdict(hello_t h);
		verdict_t v;
		int idx, slot;
		logic [15:0] m;
		bit ch, flip, pch;
		v = '0;
		ch = 0;
		idx = find_addr(h.addr);
		if (h.req == REQ_ADD) begin
			if (idx >= 0) v.status = ST_DUP;
			else begin
				slot = -1;
				for (int i = 0; i < NB; i++)
					if (!t_valid[i] && slot < 0) slot = i;
				if (slot < 0) v.status = ST_FULL;
				else begin
					t_valid[slot] = 1;
					t_addr[slot] = h.addr;
					t_pri[slot] = h.pri;
					t_fpri[slot] = h.has_pri;
					t_flan[slot] = h.has_lan;
					t_delay[slot] = h.delay;
					t_ivl[slot] = h.ovr;
					if (h.delay > max_delay) max_delay = h.delay;
					if (h.ovr > max_ivl) max_ivl = h.ovr;
					if (!h.has_lan) nolan++;
					if (!h.has_pri) nopri++;
					ch = run_election();
				end
			end
		end else if (h.req == REQ_UPD) begin
			if (idx < 0) v.status = ST_NOTFOUND;
			else begin
				flip = t_fpri[idx] != h.has_pri;
				if (flip) begin
					if (h.has_pri) begin
						if (nopri != 0) nopri--;
					end else nopri++;
				end
				pch = flip || t_pri[idx] != h.pri;
				t_pri[idx] = h.has_pri ? h.pri : 32'd0;
				if (pch) ch = run_election();
				if (t_flan[idx] != h.has_lan) begin
					if (t_flan[idx]) nolan++;
					else if (nolan != 0) nolan--;
				end
				t_fpri[idx] = h.has_pri;
				t_flan[idx] = h.has_lan;
			end
		end else if (h.req == REQ_DEL) begin
			if (idx < 0) v.status = ST_NOTFOUND;
			else begin
				if (!t_flan[idx] && nolan != 0) nolan--;
				if (!t_fpri[idx] && nopri != 0) nopri--;
				if (nolan == 0) begin
					if (t_delay[idx] == max_delay) begin
						m = p_own_delay;
						for (int i = 0; i < NB; i++)
							if (i != idx && t_valid[i] && t_delay[i] > m) m = t_delay[i];
						max_delay = m;
					end
					if (t_ivl[idx] == max_ivl) begin
						m = p_own_ovr;
						for (int i = 0; i < NB; i++)
							if (i != idx && t_valid[i] && t_ivl[i] > m) m = t_ivl[i];
						max_ivl = m;
					end
				end
				t_valid[idx] = 0;
				ch = run_election();
			end
		end
		v.dr = cur_dr;
		v.changed = ch;
		v.self_dr = cur_dr == p_own_addr;
		v.hi_delay = max_delay;
		v.hi_ivl = max_ivl;
		v.nopri = nopri > 63 ? 6'd63 : nopri[5:0];
		v.nolan = nolan > 63 ? 6'd63 : nolan[5:0];
		return v;
	endfunction

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		verdict_t got, want;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[49:34],
				m_tdata[65:50], m_tdata[71:66], m_tdata[77:72]};
			checked++;
			if (pending_verdicts.size() == 0) report("unexpected word", 32'd0, 32'd0);
			else begin
				want = pending_verdicts.pop_front();
				if (got.status !== want.status) report("status", got.status, want.status);
				if (got.dr !== want.dr) report("dr_address", got.dr, want.dr);
				if (got.changed !== want.changed) report("dr_changed", got.changed, want.changed);
				if (got.self_dr !== want.self_dr) report("i_am_dr", got.self_dr, want.self_dr);
				if (got.hi_delay !== want.hi_delay)
					report("highest_delay", got.hi_delay, want.hi_delay);
				if (got.hi_ivl !== want.hi_ivl)
					report("highest_interval", got.hi_ivl, want.hi_ivl);
				if (got.nopri !== want.nopri) report("no_priority_count", got.nopri, want.nopri);
				if (got.nolan !== want.nolan) report("no_landelay_count", got.nolan, want.nolan);
			end
		end
		if (hold_off) m_tready <= 0;
		else if (cycles % 512 < 128) m_tready <= 1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk)
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[multicast_neighbor_dr_election_core] ERROR");
			$finish;
		end

	int burst_left = 0;

	task automatic send_hello(hello_t h);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end else begin
			@(posedge clk);
		end
		burst_left--;
		s_tvalid <= 1;
		s_tuser <= h.req;
		s_tdata <= {6'd0, h.ovr, h.delay, h.has_lan, h.has_pri, h.pri, h.addr};
		do @(posedge clk); while (!s_tready);
		pending_verdicts.push_back(predict_verdict(h));
		sent++;
		if (h.req == REQ_ADD) known_addrs.push_back(h.addr);
		s_tvalid <= 0;
	endtask

	task automatic drain();
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_OWN_ADDR: p_own_addr = val;
			REG_OWN_PRI: p_own_pri = val;
			REG_OWN_DELAY: p_own_delay = val[15:0];
			default: p_own_ovr = val[15:0];
		endcase
		@(posedge clk);
	endtask

	function automatic hello_t mk(logic [1:0] r, logic [31:0] a, logic [31:0] p, bit hp,
			bit hl, logic [15:0] d, logic [15:0] o);
		return '{r, a, p, hp, hl, d, o};
	endfunction

	function automatic logic [31:0] pick_addr();
		if (known_addrs.size() != 0 && $urandom_range(0, 3) != 0)
			return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
		if ($urandom_range(0, 1)) return $urandom_range(0, 40);
		return $urandom;
	endfunction

	function automatic hello_t random_hello();
		hello_t h;
		int r;
		r = $urandom_range(0, 19);
		h.req = r < 8 ? REQ_ADD : r < 14 ? REQ_UPD : r < 19 ? REQ_DEL : 2'd3;
		h.addr = pick_addr();
		h.pri = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 4);
		h.has_pri = $urandom_range(0, 4) != 0;
		h.has_lan = $urandom_range(0, 3) != 0;
		h.delay = 16'($urandom);
		h.ovr = 16'($urandom);
		return h;
	endfunction

	task automatic test_directed();
		send_hello(mk(REQ_DEL, 32'h5, 0, 1, 1, 0, 0));
		send_hello(mk(REQ_UPD, 32'h5, 0, 1, 1, 0, 0));
		send_hello(mk(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 16'hFFFF, 16'hFFFF));
		send_hello(mk(REQ_ADD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		send_hello(mk(REQ_ADD, 32'h0, 0, 0, 0, 0, 0));
		send_hello(mk(REQ_UPD, 32'h0, 32'h7, 1, 1, 16'h1, 16'h1));
		send_hello(mk(REQ_UPD, 32'h0, 32'h7, 1, 0, 16'h1, 16'h1));
		send_hello(mk(REQ_UPD, 32'hFFFF_FFFF, 32'h9, 0, 1, 0, 0));
		send_hello(mk(2'd3, 32'h0, 32'hFFFF_FFFF, 1, 1, 16'hFFFF, 16'hFFFF));
		send_hello(mk(REQ_DEL, 32'h0, 0, 0, 0, 0, 0));
		send_hello(mk(REQ_DEL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		send_hello(mk(REQ_ADD, 32'h1234, 32'h2, 1, 1, 16'd900, 16'd3000));
		send_hello(mk(REQ_ADD, 32'h1235, 32'h2, 1, 1, 16'd800, 16'd100));
		send_hello(mk(REQ_DEL, 32'h1234, 0, 0, 0, 0, 0));
		send_hello(mk(REQ_DEL, 32'h1235, 0, 0, 0, 0, 0));
	endtask

	task automatic test_table_full();
		for (int i = 0; i < NB + 2; i++)
			send_hello(mk(REQ_ADD, 32'h100 + i, 32'(i), i % 3 != 0, i % 4 != 0,
				16'(i * 97), 16'(i * 31)));
		for (int i = 0; i < NB + 1; i++)
			send_hello(mk(REQ_DEL, 32'h100 + i, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 99) known_addrs.delete();
			send_hello(random_hello());
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			test_random(8);
		join
		drain();
	endtask

	task automatic test_config(logic [31:0] a, logic [31:0] p, logic [15:0] d, logic [15:0] o);
		write_reg(REG_OWN_ADDR, a);
		write_reg(REG_OWN_PRI, p);
		write_reg(REG_OWN_DELAY, {16'd0, d});
		write_reg(REG_OWN_OVR, {16'd0, o});
	endtask

	initial begin
		for (int i = 0; i < NB; i++) begin
			t_valid[i] = 0; t_addr[i] = 0; t_pri[i] = 0; t_fpri[i] = 0;
			t_flan[i] = 0; t_delay[i] = 0; t_ivl[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		drain();
		test_config(32'h0000_0010, 32'h0, 16'd0, 16'd0);
		test_table_full();
		test_random(150);
		drain();
		test_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		test_random(150);
		test_backpressure();
		test_config(32'h0000_0003, 32'h2, 16'd500, 16'd2500);
		test_random(200);
		drain();
		test_config($urandom_range(0, 40), $urandom_range(0, 4), 16'($urandom),
			16'($urandom));
		test_random(150);
		drain();
		$display("covered %0d requests, %0d results: add/update/delete, full table,", sent,
			checked);
		$display("unknown and duplicate addresses, four register settings, long stall");
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("[multicast_neighbor_dr_election_core] OK");
		else
			$display("[multicast_neighbor_dr_election_core] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
